FILE: src/bcbp_pkg.sv
// ----------------------------------------------------------------------------
// bcbp_pkg: shared types and constants for the bit cursor buffer packer
// Operation codes, request and response payloads, and controller states.
// ----------------------------------------------------------------------------
package bcbp_pkg;

   // Operation codes carried in a request
   typedef enum logic [2:0] {
      OP_WRITE_BITS  = 3'd0,
      OP_READ_BITS   = 3'd1,
      OP_ALIGN       = 3'd2,
      OP_REWIND      = 3'd3,
      OP_SET_CURSOR  = 3'd4,
      OP_CLEAR       = 3'd5,
      OP_POKE_BYTE   = 3'd6,
      OP_PEEK_BYTE   = 3'd7
   } op_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_BYTES,
      ST_PEEK,
      ST_FINISH
   } state_type;

   // Largest bit count of one access, and bytes one access can touch
   localparam logic [6:0] MAX_BITS  = 7'd64;
   localparam int         MAX_LANES = 9;

   typedef struct packed {
      op_type      op;
      logic [6:0]  bit_len;
      logic [63:0] value;
      logic [11:0] amount;
      logic [7:0]  byte_address;
   } req_type;

   typedef struct packed {
      logic [63:0] read_value;
      logic [11:0] position;
      logic        status;
      logic        failed;
   } rsp_type;

endpackage

FILE: src/bit_cursor_buffer_packer.sv
// ----------------------------------------------------------------------------
// bit_cursor_buffer_packer: byte buffer with one LSB-first bit cursor
// Packs or unpacks 1 to 64 bits at the cursor through a byte-wide memory,
// and handles align, rewind, set cursor, clear, poke and peek.
// ----------------------------------------------------------------------------
//
//   channel  ports                           direction  payload
//   req      req_valid req_stall req_data    in         bcbp_pkg::req_type
//   rsp      rsp_valid rsp_stall rsp_data    out        bcbp_pkg::rsp_type
//
// Write/read bits touch n = ceil((cursor % 8 + count) / 8) bytes per request
// (at most 9); a zero count or a rejected move touches none. The byte memory has one
// read and one write port, one byte a cycle.
// Align, rewind, set cursor, poke and peek touch at most one byte; clear runs
// the zeroing pass over the memory before it responds.
// After reset the same pass runs with req_stall high.
// A stalled response sits in the output register; the next request is taken
// meanwhile and waits in the finish step until the register frees up.
module bit_cursor_buffer_packer #(
   parameter int BUFFER_BYTES = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bcbp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bcbp_pkg::rsp_type rsp_data
);

   localparam int CAP   = BUFFER_BYTES * 8;
   localparam int CUR_W = $clog2(CAP + 1);
   localparam int AW    = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
   localparam int XW    = CUR_W + 8;
   localparam logic [XW-1:0] CAP_X   = XW'(CAP);
   localparam logic [XW-1:0] BYTES_X = XW'(BUFFER_BYTES);
   localparam logic [AW-1:0] LAST_IDX = AW'(BUFFER_BYTES - 1);

   // Byte memory
   logic [7:0]    mem [BUFFER_BYTES];
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [7:0]    mem_wd;
   logic [AW-1:0] mem_ra;
   logic [7:0]    mem_q_ff;

   // Control state
   bcbp_pkg::state_type state_ff, state_in;
   logic [CUR_W-1:0] cursor_ff, cursor_in;
   logic             fail_ff, fail_in;
   logic [AW-1:0]    sweep_idx_ff, sweep_idx_in;
   logic             sweep_reply_ff, sweep_reply_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Byte loop state
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic [AW-1:0] wr_idx_ff, wr_idx_in;
   logic [3:0]    left_ff, left_in;
   logic [3:0]    k_ff, k_in;
   logic [71:0]   acc_ff, acc_in;
   logic [71:0]   wdata_ff, wdata_in;
   logic [71:0]   wmask_ff, wmask_in;
   logic [63:0]   mask_ff, mask_in;
   logic [2:0]    off_ff, off_in;
   logic          is_write_ff, is_write_in;

   // Pending result and output register
   logic [63:0]       res_value_ff, res_value_in;
   logic              res_status_ff, res_status_in;
   bcbp_pkg::rsp_type rsp_ff, rsp_in;

   // Request decode helpers
   logic              req_accept;
   logic [6:0]        count_sat;
   logic [63:0]       count_mask;
   logic [XW-1:0]     cursor_x;
   logic [XW-1:0]     move_x;
   logic [XW-4:0]     align_byte;
   logic [XW-1:0]     align_x;
   logic [XW-1:0]     amount_x;
   logic [XW-1:0]     rewind_x;
   logic [XW-1:0]     addr_x;
   logic              addr_ok;
   logic [AW+7:0]     addr_ext;
   logic [AW-1:0]     addr_idx;
   logic [AW+CUR_W-4:0] cur_ext;
   logic [AW-1:0]     cur_idx;
   logic [6:0]        nb_sum;
   logic [3:0]        nb;
   logic [CUR_W+11:0] pos_ext;

   // Byte loop datapath
   logic [71:0] acc_fill;
   logic [71:0] acc_shift;
   logic [63:0] read_bits;
   logic [7:0]  merged;

   assign req_stall  = (state_ff != bcbp_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // Request field preparation
   assign count_sat  = (req_data.bit_len > bcbp_pkg::MAX_BITS) ? bcbp_pkg::MAX_BITS
                                                               : req_data.bit_len;
   assign count_mask = (count_sat == bcbp_pkg::MAX_BITS) ? '1
                                                         : ((64'd1 << count_sat) - 64'd1);
   assign cursor_x   = {8'd0, cursor_ff};
   assign move_x     = cursor_x + {{(XW-7){1'b0}}, count_sat};
   assign align_byte = {8'd0, cursor_ff[CUR_W-1:3]} + 1'b1;
   assign align_x    = {align_byte, 3'b000};
   assign amount_x   = {{(XW-12){1'b0}}, req_data.amount};
   assign rewind_x   = (cursor_x > amount_x) ? (cursor_x - amount_x) : '0;
   assign addr_x     = {{(XW-8){1'b0}}, req_data.byte_address};
   assign addr_ok    = (addr_x < BYTES_X);
   assign addr_ext   = {{AW{1'b0}}, req_data.byte_address};
   assign addr_idx   = addr_ext[AW-1:0];
   assign cur_ext    = {{AW{1'b0}}, cursor_ff[CUR_W-1:3]};
   assign cur_idx    = cur_ext[AW-1:0];
   assign nb_sum     = {4'd0, cursor_ff[2:0]} + count_sat + 7'd7;
   assign nb         = nb_sum[6:3];
   assign pos_ext    = {12'd0, cursor_ff};

   // Gather the arriving byte into its lane and line up the read bits
   always_comb begin
      acc_fill = acc_ff;
      for (int i = 0; i < bcbp_pkg::MAX_LANES; i++) begin
         if (k_ff == 4'(i)) begin
            acc_fill[8*i +: 8] = mem_q_ff;
         end
      end
      acc_shift = acc_fill >> off_ff;
      read_bits = acc_shift[63:0] & mask_ff;
   end

   // Read-modify-write merge of one byte
   assign merged = (mem_q_ff & ~wmask_ff[7:0]) | (wdata_ff[7:0] & wmask_ff[7:0]);

   // Next state, memory control and results
   always_comb begin
      state_in       = state_ff;
      cursor_in      = cursor_ff;
      fail_in        = fail_ff;
      sweep_idx_in   = sweep_idx_ff;
      sweep_reply_in = sweep_reply_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_in         = rsp_ff;
      rd_idx_in      = rd_idx_ff;
      wr_idx_in      = wr_idx_ff;
      left_in        = left_ff;
      k_in           = k_ff;
      acc_in         = acc_ff;
      wdata_in       = wdata_ff;
      wmask_in       = wmask_ff;
      mask_in        = mask_ff;
      off_in         = off_ff;
      is_write_in    = is_write_ff;
      res_value_in   = res_value_ff;
      res_status_in  = res_status_ff;
      mem_we         = 1'b0;
      mem_wa         = wr_idx_ff;
      mem_wd         = merged;
      mem_ra         = rd_idx_ff;

      // response leaves when taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         bcbp_pkg::ST_SWEEP: begin
            mem_we       = 1'b1;
            mem_wa       = sweep_idx_ff;
            mem_wd       = 8'd0;
            sweep_idx_in = sweep_idx_ff + 1'b1;
            if (sweep_idx_ff == LAST_IDX) begin
               sweep_idx_in = '0;
               state_in     = sweep_reply_ff ? bcbp_pkg::ST_FINISH : bcbp_pkg::ST_IDLE;
            end
         end

         bcbp_pkg::ST_IDLE: begin
            if (req_accept) begin
               res_value_in  = '0;
               res_status_in = 1'b0;
               state_in      = bcbp_pkg::ST_FINISH;
               unique case (req_data.op) inside
                  bcbp_pkg::OP_WRITE_BITS, bcbp_pkg::OP_READ_BITS: begin
                     if (move_x > CAP_X) begin
                        fail_in       = 1'b1;
                        res_status_in = 1'b1;
                     end else begin
                        cursor_in = move_x[CUR_W-1:0];
                        if (count_sat != 7'd0) begin
                           // first byte read goes out now
                           mem_ra      = cur_idx;
                           rd_idx_in   = cur_idx + 1'b1;
                           wr_idx_in   = cur_idx;
                           left_in     = nb - 4'd1;
                           k_in        = 4'd0;
                           acc_in      = '0;
                           wdata_in    = {8'd0, req_data.value} << cursor_ff[2:0];
                           wmask_in    = {8'd0, count_mask} << cursor_ff[2:0];
                           mask_in     = count_mask;
                           off_in      = cursor_ff[2:0];
                           is_write_in = (req_data.op == bcbp_pkg::OP_WRITE_BITS);
                           state_in    = bcbp_pkg::ST_BYTES;
                        end
                     end
                  end
                  bcbp_pkg::OP_ALIGN: begin
                     if (align_x > CAP_X) begin
                        fail_in       = 1'b1;
                        res_status_in = 1'b1;
                     end else begin
                        cursor_in = align_x[CUR_W-1:0];
                     end
                  end
                  bcbp_pkg::OP_REWIND: begin
                     cursor_in = rewind_x[CUR_W-1:0];
                  end
                  bcbp_pkg::OP_SET_CURSOR: begin
                     if (amount_x > CAP_X) begin
                        fail_in       = 1'b1;
                        res_status_in = 1'b1;
                     end else begin
                        cursor_in = amount_x[CUR_W-1:0];
                     end
                  end
                  bcbp_pkg::OP_CLEAR: begin
                     cursor_in      = '0;
                     fail_in        = 1'b0;
                     sweep_idx_in   = '0;
                     sweep_reply_in = 1'b1;
                     state_in       = bcbp_pkg::ST_SWEEP;
                  end
                  bcbp_pkg::OP_POKE_BYTE: begin
                     if (addr_ok) begin
                        mem_we = 1'b1;
                        mem_wa = addr_idx;
                        mem_wd = req_data.value[7:0];
                     end
                  end
                  bcbp_pkg::OP_PEEK_BYTE: begin
                     if (addr_ok) begin
                        mem_ra   = addr_idx;
                        state_in = bcbp_pkg::ST_PEEK;
                     end
                  end
                  default: begin
                     state_in = bcbp_pkg::ST_FINISH;
                  end
               endcase
            end
         end

         bcbp_pkg::ST_BYTES: begin
            // issue the next read while the current byte is merged
            if (left_ff != 4'd0) begin
               mem_ra    = rd_idx_ff;
               rd_idx_in = rd_idx_ff + 1'b1;
               wr_idx_in = rd_idx_ff;
               left_in   = left_ff - 4'd1;
            end
            if (is_write_ff) begin
               mem_we = 1'b1;
               mem_wa = wr_idx_ff;
               mem_wd = merged;
            end
            wdata_in = wdata_ff >> 8;
            wmask_in = wmask_ff >> 8;
            acc_in   = acc_fill;
            k_in     = k_ff + 4'd1;
            if (left_ff == 4'd0) begin
               res_value_in = is_write_ff ? 64'd0 : read_bits;
               state_in     = bcbp_pkg::ST_FINISH;
            end
         end

         bcbp_pkg::ST_PEEK: begin
            res_value_in = {56'd0, mem_q_ff};
            state_in     = bcbp_pkg::ST_FINISH;
         end

         bcbp_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in        = 1'b1;
               rsp_in.read_value   = res_value_ff;
               rsp_in.position     = pos_ext[11:0];
               rsp_in.status       = res_status_ff;
               rsp_in.failed       = fail_ff;
               sweep_reply_in      = 1'b0;
               state_in            = bcbp_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = bcbp_pkg::ST_IDLE;
         end
      endcase
   end

   // Byte memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_q_ff <= mem[mem_ra];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= bcbp_pkg::ST_SWEEP;
         cursor_ff      <= '0;
         fail_ff        <= 1'b0;
         sweep_idx_ff   <= '0;
         sweep_reply_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cursor_ff      <= cursor_in;
         fail_ff        <= fail_in;
         sweep_idx_ff   <= sweep_idx_in;
         sweep_reply_ff <= sweep_reply_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      wr_idx_ff     <= wr_idx_in;
      left_ff       <= left_in;
      k_ff          <= k_in;
      acc_ff        <= acc_in;
      wdata_ff      <= wdata_in;
      wmask_ff      <= wmask_in;
      mask_ff       <= mask_in;
      off_ff        <= off_in;
      is_write_ff   <= is_write_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_ff        <= rsp_in;
   end

endmodule

FILE: bench/tb_bit_cursor_buffer_packer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bit_cursor_buffer_packer: self-checking bench for the bit cursor packer
// Drives directed and random requests with random gaps and response stalls,
// predicts each response from a shadow copy of the byte store, cursor and
// fail flag, and compares every response field by field in order.
// ----------------------------------------------------------------------------
module tb_bit_cursor_buffer_packer;

   localparam int BUFFER_BYTES  = 256;
   localparam int CAPACITY_BITS = BUFFER_BYTES * 8;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_CYCLES  = 300;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   bcbp_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   bcbp_pkg::rsp_type rsp_data;

   // Shadow state of the block
   logic [7:0] shadow_bytes [BUFFER_BYTES];
   int         shadow_cursor;
   logic       shadow_failed;

   bcbp_pkg::rsp_type expected_rsps [$];
   bcbp_pkg::rsp_type oldest_rsp;
   int         mismatch_count;
   int         cycle_count;
   bit         gaps_on;

   bit_cursor_buffer_packer #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Clock, 4 ns period
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic report_mismatch(input string field, input logic [63:0] want,
                                  input logic [63:0] got);
      $display("[%0t] %s: expected %h, got %h", $time, field, want, got);
      mismatch_count++;
   endtask

   function automatic void clear_shadow();
      foreach (shadow_bytes[i]) shadow_bytes[i] = 8'h00;
      shadow_cursor = 0;
      shadow_failed = 1'b0;
   endfunction

   // Predict the response of one request and update the shadow state
   function automatic bcbp_pkg::rsp_type apply_request(bcbp_pkg::req_type r);
      bcbp_pkg::rsp_type res;
      int      count;
      int      target;
      int      pos;
      res   = '0;
      count = int'((r.bit_len > bcbp_pkg::MAX_BITS) ? bcbp_pkg::MAX_BITS : r.bit_len);
      case (r.op) inside
         bcbp_pkg::OP_WRITE_BITS, bcbp_pkg::OP_READ_BITS: begin
            target = shadow_cursor + count;
            if (target > CAPACITY_BITS) begin
               shadow_failed = 1'b1;
               res.status    = 1'b1;
            end else begin
               for (int i = 0; i < count; i++) begin
                  pos = shadow_cursor + i;
                  if (r.op == bcbp_pkg::OP_WRITE_BITS)
                     shadow_bytes[pos >> 3][pos % 8] = r.value[i];
                  else
                     res.read_value[i] = shadow_bytes[pos >> 3][pos % 8];
               end
               shadow_cursor = target;
            end
         end
         bcbp_pkg::OP_ALIGN: begin
            // always on to the next byte boundary, even from a boundary
            target = ((shadow_cursor >> 3) + 1) << 3;
            if (target > CAPACITY_BITS) begin
               shadow_failed = 1'b1;
               res.status    = 1'b1;
            end else begin
               shadow_cursor = target;
            end
         end
         bcbp_pkg::OP_REWIND: begin
            shadow_cursor = (shadow_cursor > int'(r.amount)) ?
                            shadow_cursor - int'(r.amount) : 0;
         end
         bcbp_pkg::OP_SET_CURSOR: begin
            if (int'(r.amount) > CAPACITY_BITS) begin
               shadow_failed = 1'b1;
               res.status    = 1'b1;
            end else begin
               shadow_cursor = int'(r.amount);
            end
         end
         bcbp_pkg::OP_CLEAR: begin
            clear_shadow();
         end
         bcbp_pkg::OP_POKE_BYTE: begin
            if (r.byte_address < BUFFER_BYTES) shadow_bytes[r.byte_address] = r.value[7:0];
         end
         default: begin
            if (r.byte_address < BUFFER_BYTES)
               res.read_value = {56'd0, shadow_bytes[r.byte_address]};
         end
      endcase
      res.position = shadow_cursor[11:0];
      res.failed   = shadow_failed;
      return res;
   endfunction

   function automatic bcbp_pkg::req_type build_request(bcbp_pkg::op_type op, int count,
                                                       logic [63:0] val, int amt, int addr);
      bcbp_pkg::req_type r;
      r.op           = op;
      r.bit_len      = count[6:0];
      r.value        = val;
      r.amount       = amt[11:0];
      r.byte_address = addr[7:0];
      return r;
   endfunction

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // Random request with a weighted operation mix
   function automatic bcbp_pkg::req_type random_request();
      bcbp_pkg::req_type r;
      int      pick;
      int      count;
      int      amt;
      bcbp_pkg::op_type op;
      pick = $urandom_range(99);
      if (pick < 30)       op = bcbp_pkg::OP_WRITE_BITS;
      else if (pick < 60)  op = bcbp_pkg::OP_READ_BITS;
      else if (pick < 68)  op = bcbp_pkg::OP_ALIGN;
      else if (pick < 76)  op = bcbp_pkg::OP_REWIND;
      else if (pick < 86)  op = bcbp_pkg::OP_SET_CURSOR;
      else if (pick < 88)  op = bcbp_pkg::OP_CLEAR;
      else if (pick < 94)  op = bcbp_pkg::OP_POKE_BYTE;
      else                 op = bcbp_pkg::OP_PEEK_BYTE;
      count = ($urandom_range(99) < 85) ? $urandom_range(1, 64) : $urandom_range(0, 127);
      pick  = $urandom_range(99);
      if (op == bcbp_pkg::OP_SET_CURSOR)
         amt = (pick < 40) ? $urandom_range(CAPACITY_BITS - 70, CAPACITY_BITS + 50) :
               (pick < 80) ? $urandom_range(0, CAPACITY_BITS) : $urandom_range(0, 4095);
      else
         amt = (pick < 80) ? $urandom_range(0, 64) : $urandom_range(0, 4095);
      r = build_request(op, count, random_word(), amt, $urandom_range(0, 255));
      return r;
   endfunction

   // Send one request; starts and ends at a falling edge, valid stays high
   task automatic send_request(input bcbp_pkg::req_type r);
      while (gaps_on && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      expected_rsps.push_back(apply_request(r));
      @(negedge clock);
   endtask

   // Response stalls
   always @(negedge clock) begin
      rsp_stall <= gaps_on && ($urandom_range(99) < 33);
   end

   // Response checking
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("response with no request pending", '0, rsp_data.read_value);
         end else begin
            oldest_rsp = expected_rsps.pop_front();
            if (rsp_data.read_value !== oldest_rsp.read_value)
               report_mismatch("read_value", oldest_rsp.read_value, rsp_data.read_value);
            if (rsp_data.position !== oldest_rsp.position)
               report_mismatch("position", 64'(oldest_rsp.position),
                               64'(rsp_data.position));
            if (rsp_data.status !== oldest_rsp.status)
               report_mismatch("status", 64'(oldest_rsp.status), 64'(rsp_data.status));
            if (rsp_data.failed !== oldest_rsp.failed)
               report_mismatch("failed", 64'(oldest_rsp.failed), 64'(rsp_data.failed));
         end
      end
   end

   // Field extremes, every operation, and the boundary cases
   task automatic test_directed();
      logic [63:0] pattern;
      pattern = random_word();
      send_request(build_request(bcbp_pkg::OP_PEEK_BYTE, 0, '0, 0, 0));
      send_request(build_request(bcbp_pkg::OP_WRITE_BITS, 64, '1, 0, 0));
      send_request(build_request(bcbp_pkg::OP_WRITE_BITS, 1, '0, 0, 0));
      // zero count moves nothing
      send_request(build_request(bcbp_pkg::OP_WRITE_BITS, 0, '1, 0, 0));
      // count above 64 saturates
      send_request(build_request(bcbp_pkg::OP_WRITE_BITS, 127, pattern, 0, 0));
      send_request(build_request(bcbp_pkg::OP_SET_CURSOR, 0, '0, 0, 0));
      send_request(build_request(bcbp_pkg::OP_READ_BITS, 64, '0, 0, 0));
      send_request(build_request(bcbp_pkg::OP_READ_BITS, 1, '0, 0, 0));
      send_request(build_request(bcbp_pkg::OP_READ_BITS, 0, '0, 0, 0));
      send_request(build_request(bcbp_pkg::OP_READ_BITS, 100, '0, 0, 0));
      // align from mid-byte, then from a boundary
      send_request(build_request(bcbp_pkg::OP_ALIGN, 0, '0, 0, 0));
      send_request(build_request(bcbp_pkg::OP_ALIGN, 0, '0, 0, 0));
      send_request(build_request(bcbp_pkg::OP_REWIND, 0, '0, 3, 0));
      send_request(build_request(bcbp_pkg::OP_REWIND, 0, '0, 4095, 0));
      // cursor at capacity is legal, anything past it is rejected
      send_request(build_request(bcbp_pkg::OP_SET_CURSOR, 0, '0, CAPACITY_BITS, 0));
      send_request(build_request(bcbp_pkg::OP_WRITE_BITS, 1, '1, 0, 0));
      send_request(build_request(bcbp_pkg::OP_READ_BITS, 1, '0, 0, 0));
      send_request(build_request(bcbp_pkg::OP_ALIGN, 0, '0, 0, 0));
      send_request(build_request(bcbp_pkg::OP_SET_CURSOR, 0, '0, CAPACITY_BITS + 1, 0));
      send_request(build_request(bcbp_pkg::OP_SET_CURSOR, 0, '0, 4095, 0));
      send_request(build_request(bcbp_pkg::OP_SET_CURSOR, 0, '0, CAPACITY_BITS - 1, 0));
      send_request(build_request(bcbp_pkg::OP_ALIGN, 0, '0, 0, 0));
      send_request(build_request(bcbp_pkg::OP_POKE_BYTE, 0, random_word(), 0, 255));
      send_request(build_request(bcbp_pkg::OP_PEEK_BYTE, 0, '0, 0, 255));
      send_request(build_request(bcbp_pkg::OP_CLEAR, 0, '0, 0, 0));
      send_request(build_request(bcbp_pkg::OP_PEEK_BYTE, 0, '0, 0, 255));
   endtask

   // Write a run of chunks at a random cursor, then read the same chunks back
   task automatic test_write_read_back(input int sessions);
      int chunk_bits [8];
      int chunks;
      int start;
      for (int s = 0; s < sessions; s++) begin
         chunks = $urandom_range(1, 8);
         start  = $urandom_range(0, CAPACITY_BITS - 1);
         send_request(build_request(bcbp_pkg::OP_SET_CURSOR, 0, '0, start, 0));
         for (int i = 0; i < chunks; i++) begin
            chunk_bits[i] = $urandom_range(1, 64);
            send_request(build_request(bcbp_pkg::OP_WRITE_BITS, chunk_bits[i],
                                       random_word(), 0, 0));
         end
         send_request(build_request(bcbp_pkg::OP_SET_CURSOR, 0, '0, start, 0));
         for (int i = 0; i < chunks; i++)
            send_request(build_request(bcbp_pkg::OP_READ_BITS, chunk_bits[i], '0, 0, 0));
      end
   endtask

   task automatic test_random_mix(input int items);
      for (int i = 0; i < items; i++) send_request(random_request());
   endtask

   // Back-to-back requests with the response side never stalling
   task automatic test_steady_stream(input int items);
      gaps_on = 1'b0;
      for (int i = 0; i < items; i++) send_request(random_request());
      gaps_on = 1'b1;
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_stall      = 1'b0;
      gaps_on        = 1'b1;
      mismatch_count = 0;
      clear_shadow();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_write_read_back(40);
      test_random_mix(225);
      test_steady_stream(60);

      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_rsps.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: files.f
src/bcbp_pkg.sv
src/bit_cursor_buffer_packer.sv
bench/tb_bit_cursor_buffer_packer.sv
